// ===== rtl/rbps_pkg.sv =====
package rbps_pkg;
  localparam int DataWidth       = 64;
  localparam int WordBitsDefault = 64;
  localparam int InputBitsDefault = 32;
  localparam int PrefixWidth     = 63;
  localparam int LenWidth        = 6;
  localparam int StatusWidth     = 2;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_PREFIX   = 2'd3
  } status_e;
endpackage

// ===== rtl/rational_binary_period_split_top.sv =====
// Binary period split of a rational p/q.
// Input: numerator_i/denominator_i are taken at a clock edge with start high
// and busy low. busy stays high while the word is in work.
// Output: one result word per input, shown for one cycle with done_o high;
// the receiver cannot hold it off, so it must take it that cycle.
// Work per word: a binary gcd (one subtract or shift per cycle), two
// divisions on the shared bit-serial divider, stripping factors of two from
// the reduced denominator (up to 63), the period search (one trial per
// cycle, up to WORD_BITS-1), two more divisions and a shift-add multiply.
// Overflow and prefix errors end the word before the multiply.
// A zero input finishes with status 1 without leaving idle.
// Results are registered; busy drops in the cycle done_o rises, so the next
// word may be started then. Reset returns the sequencer to idle; no
// result word is pending after reset.
module rational_binary_period_split_top #(
  parameter int WORD_BITS  = rbps_pkg::WordBitsDefault,
  parameter int INPUT_BITS = rbps_pkg::InputBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [INPUT_BITS-1:0]              numerator_i,
  input  logic [INPUT_BITS-1:0]              denominator_i,
  output logic                               done_o,
  output logic [rbps_pkg::PrefixWidth-1:0]   prefix_bits_o,
  output logic [rbps_pkg::PrefixWidth-1:0]   cycle_bits_o,
  output logic [rbps_pkg::LenWidth-1:0]      cycle_length_o,
  output logic [rbps_pkg::StatusWidth-1:0]   status_o
);
  import rbps_pkg::*;

  localparam int DW = DataWidth;
  localparam int NW = 7;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_GCD   = 10'b0000000010,
    S_DIVA  = 10'b0000000100,
    S_DIVB  = 10'b0000001000,
    S_STRIP = 10'b0000010000,
    S_ORD   = 10'b0000100000,
    S_DIVK  = 10'b0001000000,
    S_DIVP  = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_e;

  state_e          state_q;
  logic [DW-1:0]   num_q, den_q, x_q, y_q, g_q, a_q, r_q, t_q, k_q, pfx_q;
  logic [NW-1:0]   sh_q, ell_q, en_q;
  logic [DW-1:0]   dvd_q, dvs_q, mul_a_q;
  logic            div_go_q, mul_go_q;
  logic            div_done, mul_done;
  logic [DW-1:0]   div_quo, div_rem, prod;
  logic [DW:0]     t_two;
  logic [DW-1:0]   t_next, h_val;
  logic [DW-1:0]   num_ext, den_ext;

  logic                   done_q;
  logic [PrefixWidth-1:0] pfx_o_q, cyc_o_q;
  logic [LenWidth-1:0]    len_o_q;
  status_e                st_o_q;

  rbps_div #(.DW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .dividend_i(dvd_q), .divisor_i(dvs_q),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  rbps_mul #(.DW(DW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .a_i(mul_a_q), .b_i(k_q),
    .done_o(mul_done), .prod_o(prod)
  );

  always_comb begin
    num_ext = DW'(numerator_i) + DW'(denominator_i);
    den_ext = DW'(denominator_i) << 1;
    // (2^en - 1) mod r, stepped one exponent at a time
    t_two   = {t_q, 1'b1};
    t_next  = (t_two >= {1'b0, r_q}) ? DW'(t_two - {1'b0, r_q}) : t_two[DW-1:0];
    h_val   = {DW{1'b1}} >> (NW'(DW) - en_q);
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_go_q <= 1'b0;
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (numerator_i == '0 || denominator_i == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (x_q == y_q) begin
            div_go_q <= 1'b1;
            state_q  <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_done) begin
            div_go_q <= 1'b1;
            state_q  <= S_DIVB;
          end
        end
        S_DIVB: if (div_done) state_q <= S_STRIP;
        S_STRIP: if (r_q[0] || ell_q == NW'(63)) state_q <= S_ORD;
        S_ORD: begin
          if (t_next == '0) begin
            div_go_q <= 1'b1;
            state_q  <= S_DIVK;
          end else if (en_q == NW'(WORD_BITS - 1)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_DIVK: begin
          if (div_done) begin
            div_go_q <= 1'b1;
            state_q  <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            if ((div_quo >> ell_q) != '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              mul_go_q <= 1'b1;
              state_q  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        num_q   <= num_ext;
        den_q   <= den_ext;
        x_q     <= num_ext;
        y_q     <= den_ext;
        sh_q    <= '0;
        pfx_o_q <= '0;
        cyc_o_q <= '0;
        len_o_q <= '0;
        st_o_q  <= ST_ZERO;
      end
      S_GCD: begin
        // binary gcd, one step a cycle
        if (x_q == y_q) begin
          g_q   <= x_q << sh_q;
          dvd_q <= num_q;
          dvs_q <= x_q << sh_q;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q  <= x_q >> 1;
          y_q  <= y_q >> 1;
          sh_q <= sh_q + 1'b1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q > y_q) begin
          x_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          a_q   <= div_quo;
          dvd_q <= den_q;
          dvs_q <= g_q;
        end
      end
      S_DIVB: begin
        if (div_done) begin
          r_q   <= div_quo;
          ell_q <= '0;
        end
      end
      S_STRIP: begin
        if (!r_q[0] && ell_q != NW'(63)) begin
          r_q   <= r_q >> 1;
          ell_q <= ell_q + 1'b1;
        end else begin
          t_q  <= '0;
          en_q <= NW'(1);
        end
      end
      S_ORD: begin
        if (t_next == '0) begin
          dvd_q <= h_val;
          dvs_q <= r_q;
        end else if (en_q == NW'(WORD_BITS - 1)) begin
          pfx_o_q <= '0;
          cyc_o_q <= '0;
          len_o_q <= '0;
          st_o_q  <= ST_OVERFLOW;
        end else begin
          t_q  <= t_next;
          en_q <= en_q + 1'b1;
        end
      end
      S_DIVK: begin
        if (div_done) begin
          k_q   <= div_quo;
          dvd_q <= a_q;
          dvs_q <= r_q;
        end
      end
      S_DIVP: begin
        if (div_done) begin
          pfx_q   <= div_quo;
          mul_a_q <= div_rem;
          pfx_o_q <= '0;
          cyc_o_q <= '0;
          len_o_q <= '0;
          st_o_q  <= ST_PREFIX;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          pfx_o_q <= pfx_q[PrefixWidth-1:0];
          cyc_o_q <= prod[PrefixWidth-1:0];
          len_o_q <= en_q[LenWidth-1:0];
          st_o_q  <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign done_o         = done_q;
  assign prefix_bits_o  = pfx_o_q;
  assign cycle_bits_o   = cyc_o_q;
  assign cycle_length_o = len_o_q;
  assign status_o       = st_o_q;
endmodule

// ===== rtl/rbps_div.sv =====
module rbps_div #(
  parameter int DW = rbps_pkg::DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   rem_sh, rem_d;
  logic          ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/rbps_mul.sv =====
module rbps_mul #(
  parameter int DW = rbps_pkg::DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] prod_o
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] acc_q, mcand_q, mplier_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit per cycle; product kept modulo 2^DW
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= a_i;
      mplier_q <= b_i;
    end else if (run_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[DW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[DW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
